// ===== rtl/mrt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrt_pkg
// Shared widths, constants and types of the modular root table.
// ----------------------------------------------------------------------------
package mrt_pkg;

   // Residue width: the table has 2^WIDTH entries of WIDTH bits.
   localparam int WIDTH    = 16;
   localparam int FIELD_W  = 16;
   localparam int EXP_W    = 16;
   localparam int STEP_W   = $clog2(EXP_W);
   localparam int INDEX_W  = WIDTH + 1;

   localparam logic [EXP_W-1:0]  EXP_RESET = EXP_W'(23333);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(EXP_W - 1);

   // Build sequencer states.
   typedef enum logic [1:0] {
      BUILD_CLEAR,
      BUILD_POW,
      BUILD_WRITE,
      BUILD_DONE
   } build_state_type;

   // Table write port.
   typedef struct packed {
      logic             en;
      logic [WIDTH-1:0] addr;
      logic [WIDTH-1:0] data;
   } wr_port_type;

   // Table read port.
   typedef struct packed {
      logic             en;
      logic [WIDTH-1:0] addr;
   } rd_port_type;

endpackage
`default_nettype wire

// ===== rtl/modular_root_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_root_table_core
// Exponent-th root modulo 2^WIDTH by lookup in a built root table.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry a residue item req_value; rsp_valid/rsp_ready
//   return rsp_root, the largest x with x^exponent mod 2^WIDTH equal to the
//   residue, or 0 when there is none. csr_wen with csr_wdata sets the
//   exponent; a new value clears and rebuilds the table.
//   After reset and after an exponent change the table is cleared, one entry
//   a cycle, and then every base is raised to the exponent with one
//   square-and-multiply step a cycle, EXP_W steps followed by one table
//   write per base. req_ready stays low during the build.
//   Once built, one item is accepted every cycle while the receiver keeps up;
//   an accepted item is registered first in the table read stage and then
//   in the output register, which drives rsp_root.
//   When the receiver stalls, the output register holds
//   its item, the read stage holds one more, and then req_ready drops.
// ----------------------------------------------------------------------------
module modular_root_table_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [mrt_pkg::FIELD_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [mrt_pkg::FIELD_W-1:0]  rsp_root,
   input  wire logic                         csr_wen,
   input  wire logic [mrt_pkg::EXP_W-1:0]    csr_wdata
);

   mrt_pkg::wr_port_type         wr_port;
   mrt_pkg::rd_port_type         rd_port;
   logic [mrt_pkg::WIDTH-1:0]    rd_data;
   logic                         table_ready;

   // Table build sequencer.
   mrt_builder u_builder (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_wdata   (csr_wdata),
      .wr_port     (wr_port),
      .table_ready (table_ready)
   );

   // Root table.
   mrt_ram #(
      .ADDR_W (mrt_pkg::WIDTH),
      .DATA_W (mrt_pkg::WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_port.en),
      .wr_addr (wr_port.addr),
      .wr_data (wr_port.data),
      .rd_en   (rd_port.en),
      .rd_addr (rd_port.addr),
      .rd_data (rd_data)
   );

   // Query pipeline.
   mrt_query u_query (
      .clock       (clock),
      .reset       (reset),
      .table_ready (table_ready),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_root    (rsp_root),
      .rd_port     (rd_port),
      .rd_data     (rd_data)
   );

endmodule
`default_nettype wire

// ===== rtl/mrt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrt_ram
// Simple dual-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module mrt_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 16
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [0:(1 << ADDR_W)-1];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port; the data holds while no read is issued.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== rtl/mrt_builder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrt_builder
// Holds the exponent, clears the root table and refills it by raising
// every base to the exponent with square-and-multiply, one bit a cycle.
// ----------------------------------------------------------------------------
module mrt_builder (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wen,
   input  wire logic [mrt_pkg::EXP_W-1:0]    csr_wdata,
   output mrt_pkg::wr_port_type              wr_port,
   output logic                              table_ready
);

   localparam int W = mrt_pkg::WIDTH;

   mrt_pkg::build_state_type state_ff, state_in;
   logic [mrt_pkg::EXP_W-1:0]   exponent_ff, exponent_in;
   logic [mrt_pkg::INDEX_W-1:0] index_ff, index_in;
   logic [mrt_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [mrt_pkg::EXP_W-1:0]   shift_ff, shift_in;
   logic [W-1:0]                acc_ff, acc_in;
   logic [W-1:0]                sq_ff, sq_in;
   logic [2*W-1:0]              acc_prod;
   logic [2*W-1:0]              sq_prod;
   logic                        restart;
   logic                        last_index;

   // A write of a new exponent, or any write before the table is done, rebuilds.
   assign restart    = csr_wen &&
                       ((csr_wdata != exponent_ff) || (state_ff != mrt_pkg::BUILD_DONE));
   assign last_index = (index_ff[W-1:0] == {W{1'b1}});

   // One square-and-multiply step.
   assign acc_prod = acc_ff * sq_ff;
   assign sq_prod  = sq_ff * sq_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mrt_pkg::BUILD_CLEAR: begin
            if (last_index) begin
               state_in = mrt_pkg::BUILD_POW;
            end
         end
         mrt_pkg::BUILD_POW: begin
            if (step_ff == mrt_pkg::LAST_STEP) begin
               state_in = mrt_pkg::BUILD_WRITE;
            end
         end
         mrt_pkg::BUILD_WRITE: begin
            if (last_index) begin
               state_in = mrt_pkg::BUILD_DONE;
            end else begin
               state_in = mrt_pkg::BUILD_POW;
            end
         end
         mrt_pkg::BUILD_DONE: begin
            state_in = mrt_pkg::BUILD_DONE;
         end
         default: begin
            state_in = mrt_pkg::BUILD_CLEAR;
         end
      endcase
      if (restart) begin
         state_in = mrt_pkg::BUILD_CLEAR;
      end
   end

   // Datapath: counters and the exponentiation registers.
   always_comb begin
      exponent_in = exponent_ff;
      index_in    = index_ff;
      step_in     = step_ff;
      shift_in    = shift_ff;
      acc_in      = acc_ff;
      sq_in       = sq_ff;
      case (state_ff)
         mrt_pkg::BUILD_CLEAR: begin
            if (last_index) begin
               // Start the first base, zero.
               index_in = '0;
               step_in  = '0;
               shift_in = exponent_ff;
               acc_in   = W'(1);
               sq_in    = '0;
            end else begin
               index_in = index_ff + mrt_pkg::INDEX_W'(1);
            end
         end
         mrt_pkg::BUILD_POW: begin
            if (shift_ff[0]) begin
               acc_in = acc_prod[W-1:0];
            end
            sq_in    = sq_prod[W-1:0];
            shift_in = shift_ff >> 1;
            step_in  = step_ff + mrt_pkg::STEP_W'(1);
         end
         mrt_pkg::BUILD_WRITE: begin
            // Move on to the next base.
            index_in = index_ff + mrt_pkg::INDEX_W'(1);
            step_in  = '0;
            shift_in = exponent_ff;
            acc_in   = W'(1);
            sq_in    = index_ff[W-1:0] + W'(1);
         end
         default: begin
         end
      endcase
      if (restart) begin
         exponent_in = csr_wdata;
         index_in    = '0;
      end
   end

   // Outputs: table write port and ready flag.
   always_comb begin
      wr_port.en   = 1'b0;
      wr_port.addr = index_ff[W-1:0];
      wr_port.data = '0;
      table_ready  = 1'b0;
      case (state_ff)
         mrt_pkg::BUILD_CLEAR: begin
            wr_port.en = 1'b1;
         end
         mrt_pkg::BUILD_WRITE: begin
            wr_port.en   = 1'b1;
            wr_port.addr = acc_ff;
            wr_port.data = index_ff[W-1:0];
         end
         mrt_pkg::BUILD_DONE: begin
            table_ready = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= mrt_pkg::BUILD_CLEAR;
         exponent_ff <= mrt_pkg::EXP_RESET;
         index_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         exponent_ff <= exponent_in;
         index_ff    <= index_in;
      end
   end

   // Exponentiation registers.
   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      shift_ff <= shift_in;
      acc_ff   <= acc_in;
      sq_ff    <= sq_in;
   end

endmodule
`default_nettype wire

// ===== rtl/mrt_query.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrt_query
// Query pipeline: issues one table read per item and carries the read
// data into an output register that holds while the receiver stalls.
// ----------------------------------------------------------------------------
module mrt_query (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         table_ready,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic [mrt_pkg::FIELD_W-1:0]  req_value,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic      [mrt_pkg::FIELD_W-1:0]  rsp_root,
   output mrt_pkg::rd_port_type              rd_port,
   input  wire logic [mrt_pkg::WIDTH-1:0]    rd_data
);

   localparam int W  = mrt_pkg::WIDTH;
   localparam int FW = mrt_pkg::FIELD_W;

   logic          read_valid_ff, read_valid_in;
   logic          out_valid_ff, out_valid_in;
   logic [FW-1:0] out_root_ff;
   logic          read_move;
   logic          accept;
   logic [FW+W-1:0] value_ext;
   logic [FW+W-1:0] data_ext;

   // The read stage moves on when the output register is free or emptying.
   assign read_move = read_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = table_ready && (!read_valid_ff || read_move);
   assign accept    = req_valid && req_ready;

   // Residue address is the low WIDTH bits of the value.
   assign value_ext    = {{W{1'b0}}, req_value};
   assign rd_port.en   = accept;
   assign rd_port.addr = value_ext[W-1:0];

   // Root field carries the low bits of the stored root.
   assign data_ext = {{FW{1'b0}}, rd_data};

   always_comb begin
      read_valid_in = accept || (read_valid_ff && !read_move);
      out_valid_in  = read_move || (out_valid_ff && !rsp_ready);
   end

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         read_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         read_valid_ff <= read_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // Output payload.
   always_ff @(posedge clock) begin
      if (read_move) begin
         out_root_ff <= data_ext[FW-1:0];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_root  = out_root_ff;

endmodule
`default_nettype wire
